// File: design/ole_pkg.sv
// Package with shared constants and types for the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;
    localparam int DefCapacity = 16;
    localparam int ValW = 32;

    localparam logic [2:0] CmdInsBefore = 3'd0;
    localparam logic [2:0] CmdInsAfter  = 3'd1;
    localparam logic [2:0] CmdDelete    = 3'd2;
    localparam logic [2:0] CmdTraverse  = 3'd3;
    localparam logic [2:0] CmdReverse   = 3'd4;
    localparam logic [2:0] CmdSort      = 3'd5;
    localparam logic [2:0] CmdDelAlt    = 3'd6;
    localparam logic [2:0] CmdInsSorted = 3'd7;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StNotFound = 3'd1;
    localparam logic [2:0] StEmpty    = 3'd2;
    localparam logic [2:0] StFew      = 3'd3;
    localparam logic [2:0] StFull     = 3'd4;

    // Compare unit request: a = memory word, b = key.
    typedef struct packed {
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic eq;
        logic gt;   // signed a > b
    } t_cmp_res;
endpackage
`default_nettype wire

// File: design/ole_cmp.sv
// Shared compare unit used by every search and sort step.
`timescale 1ns / 1ps
`default_nettype none
module ole_cmp (
    input  ole_pkg::t_cmp_req i_req,
    output ole_pkg::t_cmp_res o_res
);
    import ole_pkg::*;
    assign o_res.eq = (i_req.a == i_req.b);
    assign o_res.gt = ($signed(i_req.a) > $signed(i_req.b));
endmodule
`default_nettype wire

// File: design/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer, entry memory and output register.
// Commands walk the list one entry at a time through the memory's registered read port.
// One command at a time; i_stall on the result side holds the sequencer.
// The entry memory has one write and one registered read port, which sets the pace.
// Reset clears the entry count, the output valid and the sequencer; memory contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::DefCapacity
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [2:0]               i_command,
    input  wire logic [ole_pkg::ValW-1:0] i_value,
    input  wire logic [ole_pkg::ValW-1:0] i_reference_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [2:0]                    o_status,
    output logic [ole_pkg::ValW-1:0]      o_item_value,
    output logic                          o_has_item,
    output logic                          o_last
);
    import ole_pkg::*;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapC = CW'(CAPACITY);

    localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_SRD = 4'd2,
        S_SCMP = 4'd3, S_SHRD = 4'd4, S_SHWR = 4'd5, S_TRD = 4'd6,
        S_TOUT = 4'd7, S_RRD = 4'd8, S_RWR = 4'd9, S_OSRD = 4'd10,
        S_OSWR = 4'd11, S_OUT = 4'd12, S_ARD = 4'd13, S_AWR = 4'd14,
        S_OSCMP = 4'd15;

    logic [ValW-1:0] r_mem [CAPACITY];
    logic [ValW-1:0] r_rd;
    logic [3:0]      r_state;
    logic [CW-1:0]   r_cnt, r_i, r_j, r_k;
    logic [2:0]      r_cmd, r_st;
    logic [ValW-1:0] r_val, r_ref, r_tmp;
    logic            r_ov, r_ohas, r_olast;
    logic [ValW-1:0] r_oitem;
    logic [2:0]      r_ost;

    logic            rd_en, wr_en;
    logic [CW-1:0]   rd_a, wr_a;
    logic [ValW-1:0] wr_d;
    logic            out_load;
    t_cmp_req        creq;
    t_cmp_res        cres;

    ole_cmp u_cmp (.i_req(creq), .o_res(cres));

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_a[AW-1:0]] <= wr_d;
        if (rd_en) r_rd <= r_mem[rd_a[AW-1:0]];
    end

    // Reverse phase in r_k: 0 = fetch low entry, 1 = write high entry, 2 = write low entry.
    always_comb begin
        rd_en = 1'b0; rd_a = r_i; wr_en = 1'b0; wr_a = r_j; wr_d = r_rd;
        creq.a = r_rd;
        creq.b = (r_cmd == CmdInsBefore || r_cmd == CmdInsAfter) ? r_ref :
                 (r_cmd == CmdSort) ? r_tmp : r_val;
        case (r_state)
            S_SRD:  begin rd_en = 1'b1; rd_a = r_i; end
            S_SHRD: begin rd_en = 1'b1; rd_a = r_j - 1'b1; end
            S_SHWR: begin wr_en = 1'b1; wr_a = r_j; wr_d = r_rd; end
            S_TRD:  begin rd_en = 1'b1; rd_a = r_i; end
            S_RRD:  begin rd_en = 1'b1; rd_a = (r_k == '0) ? r_i : r_j; end
            S_RWR:  begin
                wr_en = (r_k != '0);
                wr_a = (r_k == CW'(1)) ? r_j : r_i;
                wr_d = r_tmp;
            end
            S_OSRD: begin rd_en = (r_j != '0); rd_a = r_j - 1'b1; end
            S_OSCMP: begin wr_en = cres.gt; wr_a = r_j; wr_d = r_rd; end
            S_OSWR: begin wr_en = 1'b1; wr_a = r_j; wr_d = r_tmp; end
            S_ARD:  begin rd_en = 1'b1; rd_a = r_i; end
            S_AWR:  begin wr_en = 1'b1; wr_a = r_j; wr_d = r_rd; end
            default: ;
        endcase
    end

    assign out_load = (r_state == S_TOUT || r_state == S_OUT) && (!r_ov || !i_stall);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_item_value = r_oitem;
    assign o_has_item = r_ohas;
    assign o_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_command; r_val <= i_value; r_ref <= i_reference_value;
                    r_st <= StOk; r_state <= S_DISP;
                end
                S_DISP: begin
                    case (r_cmd)
                        CmdInsBefore, CmdInsAfter, CmdInsSorted: begin
                            if (r_cnt == '0) begin
                                r_tmp <= r_val; r_j <= '0; r_state <= S_OSWR;
                            end else if (r_cnt >= CapC) begin
                                r_st <= StFull; r_state <= S_OUT;
                            end else begin
                                r_i <= '0; r_state <= S_SRD;
                            end
                        end
                        CmdDelete: begin
                            if (r_cnt == '0) begin
                                r_st <= StEmpty; r_state <= S_OUT;
                            end else begin
                                r_i <= '0; r_state <= S_SRD;
                            end
                        end
                        CmdTraverse: begin
                            if (r_cnt == '0) begin
                                r_st <= StEmpty; r_state <= S_OUT;
                            end else begin
                                r_i <= '0; r_state <= S_TRD;
                            end
                        end
                        CmdReverse: begin
                            if (r_cnt == '0) begin
                                r_st <= StEmpty; r_state <= S_OUT;
                            end else begin
                                r_i <= '0; r_j <= r_cnt - 1'b1; r_k <= '0;
                                r_state <= S_RRD;
                            end
                        end
                        CmdSort: begin
                            if (r_cnt < CW'(2)) begin
                                r_st <= StFew; r_state <= S_OUT;
                            end else begin
                                r_i <= CW'(1); r_state <= S_SRD;
                            end
                        end
                        default: begin
                            if (r_cnt < CW'(2)) begin
                                r_st <= StFew; r_state <= S_OUT;
                            end else begin
                                r_i <= '0; r_j <= '0; r_k <= '0; r_state <= S_ARD;
                            end
                        end
                    endcase
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (r_cmd == CmdSort) begin
                        // Key fetched; walk down from i.
                        r_tmp <= r_rd; r_j <= r_i; r_state <= S_OSRD;
                    end else if (r_cmd == CmdInsSorted) begin
                        if (cres.gt) begin
                            r_tmp <= r_val; r_j <= r_cnt; r_k <= r_i; r_state <= S_SHRD;
                        end else if (r_i + 1'b1 == r_cnt) begin
                            r_tmp <= r_val; r_j <= r_cnt; r_state <= S_OSWR;
                        end else begin
                            r_i <= r_i + 1'b1; r_state <= S_SRD;
                        end
                    end else if (cres.eq) begin
                        if (r_cmd == CmdDelete) begin
                            if (r_i + 1'b1 == r_cnt) begin
                                r_cnt <= r_cnt - 1'b1; r_state <= S_OUT;
                            end else begin
                                r_j <= r_i; r_state <= S_ARD; r_k <= CW'(3);
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_tmp <= r_val; r_j <= r_cnt;
                            r_k <= (r_cmd == CmdInsAfter) ? r_i + 1'b1 : r_i;
                            r_state <= (r_cnt == ((r_cmd == CmdInsAfter) ? r_i + 1'b1 : r_i))
                                       ? S_OSWR : S_SHRD;
                        end
                    end else if (r_i + 1'b1 == r_cnt) begin
                        r_st <= StNotFound; r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + 1'b1; r_state <= S_SRD;
                    end
                end
                // Open a gap at r_k by moving entries up from the end.
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    r_j <= r_j - 1'b1;
                    r_state <= (r_j - 1'b1 == r_k) ? S_OSWR : S_SHRD;
                end
                // Sort: entry j-1 is read, compared against the key and moved up if larger.
                S_OSRD: r_state <= (r_j == '0) ? S_OSWR : S_OSCMP;
                S_OSCMP: begin
                    if (cres.gt) begin
                        r_j <= r_j - 1'b1; r_state <= S_OSRD;
                    end else r_state <= S_OSWR;
                end
                S_OSWR: begin
                    if (r_cmd == CmdSort) begin
                        if (r_i + 1'b1 == r_cnt) r_state <= S_OUT;
                        else begin
                            r_i <= r_i + 1'b1; r_state <= S_SRD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1; r_state <= S_OUT;
                    end
                end
                S_TRD: r_state <= S_TOUT;
                S_TOUT: if (out_load) begin
                    r_ost <= StOk; r_oitem <= r_rd; r_ohas <= 1'b1;
                    r_olast <= (r_i + 1'b1 == r_cnt);
                    if (r_i + 1'b1 == r_cnt) r_state <= S_IDLE;
                    else begin r_i <= r_i + 1'b1; r_state <= S_TRD; end
                end
                S_RRD: r_state <= S_RWR;
                S_RWR: begin
                    if (r_k == '0) begin
                        r_tmp <= r_rd; r_k <= CW'(1); r_state <= S_RRD;
                    end else if (r_k == CW'(1)) begin
                        r_tmp <= r_rd; r_k <= CW'(2);
                    end else begin
                        r_k <= '0;
                        if (r_i + 1'b1 >= r_j - 1'b1 || r_j == '0) r_state <= S_OUT;
                        else begin
                            r_i <= r_i + 1'b1; r_j <= r_j - 1'b1; r_state <= S_RRD;
                        end
                    end
                end
                S_ARD: r_state <= S_AWR;
                S_AWR: begin
                    r_j <= r_j + 1'b1;
                    if (r_k == CW'(3)) begin
                        if (r_i + 1'b1 >= r_cnt) begin
                            r_cnt <= r_cnt - 1'b1; r_state <= S_OUT;
                        end else begin
                            r_i <= r_i + 1'b1; r_state <= S_ARD;
                        end
                    end else if (r_i >= r_cnt - CW'(2)) begin
                        r_cnt <= r_j + 1'b1; r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + CW'(2); r_state <= S_ARD;
                    end
                end
                S_OUT: if (out_load) begin
                    r_ost <= r_st; r_oitem <= '0; r_ohas <= 1'b0;
                    r_olast <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/ole_checker.sv
// Checker for the ordered list engine: predicts results from accepted items and compares them.
`timescale 1ns / 1ps
`default_nettype none
module ole_checker #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_value,
    input  wire logic [31:0] i_reference_value,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_status,
    input  wire logic [31:0] i_item_value,
    input  wire logic        i_has_item,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending
);
    import ole_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] item_value;
        logic        has_item;
        logic        last;
    } t_result;

    logic signed [31:0] list_model[CAPACITY];
    int                 count_model;
    t_result            expected_q[$];

    function automatic t_result status_res(logic [2:0] st);
        t_result r;
        r.status = st;
        r.item_value = '0;
        r.has_item = 1'b0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic insert_entry(int pos, logic signed [31:0] v);
        for (int k = count_model; k > pos; k--) list_model[k] = list_model[k - 1];
        list_model[pos] = v;
        count_model++;
    endtask

    task automatic run_command(logic [2:0] cmd, logic signed [31:0] v,
                               logic signed [31:0] rv);
        logic [2:0]         st;
        int                 pos;
        int                 j;
        t_result            r;
        logic signed [31:0] t;
        st = StOk;
        pos = -1;
        case (cmd)
            CmdInsBefore, CmdInsAfter: begin
                if (count_model == 0) begin
                    insert_entry(0, v);
                end else if (count_model >= CAPACITY) begin
                    st = StFull;
                end else begin
                    for (int k = count_model - 1; k >= 0; k--)
                        if (list_model[k] == rv) pos = k;
                    if (pos < 0) st = StNotFound;
                    else insert_entry(pos + (cmd == CmdInsAfter ? 1 : 0), v);
                end
            end
            CmdDelete: begin
                if (count_model == 0) begin
                    st = StEmpty;
                end else begin
                    for (int k = count_model - 1; k >= 0; k--)
                        if (list_model[k] == v) pos = k;
                    if (pos < 0) begin
                        st = StNotFound;
                    end else begin
                        for (int k = pos; k + 1 < count_model; k++)
                            list_model[k] = list_model[k + 1];
                        count_model--;
                    end
                end
            end
            CmdTraverse: begin
                if (count_model == 0) begin
                    expected_q.push_back(status_res(StEmpty));
                end else begin
                    for (int k = 0; k < count_model; k++) begin
                        r.status = StOk;
                        r.item_value = list_model[k];
                        r.has_item = 1'b1;
                        r.last = (k == count_model - 1);
                        expected_q.push_back(r);
                    end
                end
                return;
            end
            CmdReverse: begin
                if (count_model == 0) st = StEmpty;
                else
                    for (int k = 0; k < count_model / 2; k++) begin
                        t = list_model[k];
                        list_model[k] = list_model[count_model - 1 - k];
                        list_model[count_model - 1 - k] = t;
                    end
            end
            CmdSort: begin
                if (count_model < 2) st = StFew;
                else
                    for (int k = 1; k < count_model; k++) begin
                        t = list_model[k];
                        j = k;
                        while (j > 0 && list_model[j - 1] > t) begin
                            list_model[j] = list_model[j - 1];
                            j--;
                        end
                        list_model[j] = t;
                    end
            end
            CmdDelAlt: begin
                if (count_model < 2) begin
                    st = StFew;
                end else begin
                    j = 0;
                    for (int k = 0; k < count_model; k += 2) begin
                        list_model[j] = list_model[k];
                        j++;
                    end
                    count_model = j;
                end
            end
            default: begin
                if (count_model == 0) begin
                    insert_entry(0, v);
                end else if (count_model >= CAPACITY) begin
                    st = StFull;
                end else begin
                    j = 0;
                    while (j < count_model && list_model[j] <= v) j++;
                    insert_entry(j, v);
                end
            end
        endcase
        expected_q.push_back(status_res(st));
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            count_model = 0;
            expected_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.status !== i_status)
                        $error("status: expected %0d actual %0d", e.status, i_status);
                    if (e.item_value !== i_item_value)
                        $error("item_value: expected %0h actual %0h",
                               e.item_value, i_item_value);
                    if (e.has_item !== i_has_item)
                        $error("has_item: expected %0d actual %0d", e.has_item, i_has_item);
                    if (e.last !== i_last)
                        $error("last: expected %0d actual %0d", e.last, i_last);
                    if (e !== {i_status, i_item_value, i_has_item, i_last})
                        o_errors <= o_errors + 1;
                end
            end
            if (i_valid && !i_in_stall) run_command(i_command, i_value, i_reference_value);
            o_pending <= expected_q.size();
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench top for the ordered list engine: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import ole_pkg::*;

    localparam int Cap = 16;
    localparam int MaxCycles = 800000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [31:0] value = '0;
    logic [31:0] ref_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] item_value;
    logic        has_item;
    logic        last;
    int          errors;
    int          pending;
    int          cycles = 0;
    logic        hold_off = 1'b0;
    logic [31:0] recent[8];

    always #1 clk = ~clk;

    ordered_list_engine #(.CAPACITY(Cap)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_command(command), .i_value(value), .i_reference_value(ref_value),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status),
        .o_item_value(item_value), .o_has_item(has_item), .o_last(last)
    );

    ole_checker #(.CAPACITY(Cap)) checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_command(command), .i_value(value), .i_reference_value(ref_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_item_value(item_value), .i_has_item(has_item), .i_last(last),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MaxCycles) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: mode changes every so often, rotating through no stalls, light stalls and heavy stalls.
    always @(posedge clk) begin
        int mode;
        mode = (cycles / 300) % 3;
        if (hold_off) out_stall <= 1'b1;
        else if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
    end

    // Long receiver hold-off, counted on the common clock.
    initial begin
        wait (cycles == 2000);
        @(posedge clk) hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send(logic [2:0] c, logic [31:0] v, logic [31:0] r);
        command <= c;
        value <= v;
        ref_value <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return recent[$urandom_range(0, 7)];
            3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [31:0] v;
        int          burst;
        int          n;
        for (int k = 0; k < 8; k++) recent[k] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: empty-list cases first.
        send(CmdTraverse, 0, 0);
        send(CmdDelete, 5, 0);
        send(CmdReverse, 0, 0);
        send(CmdSort, 0, 0);
        send(CmdDelAlt, 0, 0);
        send(CmdInsBefore, 32'h8000_0000, 32'h1234);
        send(CmdSort, 0, 0);
        send(CmdDelAlt, 0, 0);
        send(CmdReverse, 0, 0);
        send(CmdInsAfter, 32'h7fff_ffff, 32'h5555);
        send(CmdInsAfter, 32'hffff_ffff, 32'h8000_0000);
        send(CmdInsSorted, 0, 0);
        send(CmdDelete, 77, 0);
        send(CmdDelete, 32'hffff_ffff, 0);
        send(CmdSort, 0, 0);
        for (int k = 0; k < 14; k++) send(CmdInsSorted, $urandom, 0);
        send(CmdInsSorted, 1, 0);
        send(CmdInsBefore, 2, 32'h7fff_ffff);
        send(CmdTraverse, 0, 0);
        send(CmdReverse, 0, 0);
        send(CmdDelAlt, 0, 0);
        send(CmdTraverse, 0, 0);
        drain();
        n = 0;
        while (n < 375) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++) begin
                v = pick_value();
                recent[$urandom_range(0, 7)] = v;
                send(3'($urandom), v, pick_value());
                n++;
            end
            if ($urandom_range(0, 40) == 0) drain();
            else if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        drain();
        repeat (1200) @(posedge clk);
        if (errors == 0 && pending == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
